FILE: hdl/yuv420_to_argb_rotate_top_defines.svh
// Assertion macros for the YUV to ARGB rotation block.
`ifndef YUV420_TO_ARGB_ROTATE_TOP_DEFINES_SVH
`define YUV420_TO_ARGB_ROTATE_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define YR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define YR_NEXT(lbl, pre, post, msg) \
	`YR_ASSERT(lbl, (pre) |=> (post), msg)

`endif

FILE: hdl/yuvrot_pkg.sv
// Shared types, widths and constants of the YUV to ARGB rotation block.
package yuvrot_pkg;

	localparam int MaxDim    = 4096;
	localparam int MaxStride = 8192;

	localparam int ChanW   = 8;
	localparam int CoordW  = $clog2(MaxDim);
	localparam int DimW    = $clog2(MaxDim) + 1;
	localparam int StrideW = $clog2(MaxStride) + 1;
	localparam int IdxW    = 26;
	localparam int ArgbW   = 32;
	localparam int AddrW   = 4;
	localparam int DataW   = 32;

	// Fixed-point arithmetic of the color conversion.
	localparam int ChromaW   = ChanW + 1;
	localparam int FracW     = 16;
	localparam int ProdW     = 25;
	localparam int SumW      = 26;
	localparam int ChromaOfs = 128;
	localparam int ChanMax   = 255;

	localparam logic signed [ProdW-1:0] CoefRv = ProdW'(91881);
	localparam logic signed [ProdW-1:0] CoefGu = ProdW'(22554);
	localparam logic signed [ProdW-1:0] CoefGv = ProdW'(46802);
	localparam logic signed [ProdW-1:0] CoefBu = ProdW'(116130);
	localparam logic [ChanW-1:0]        AlphaOpaque = 8'hFF;

	localparam logic [DimW-1:0]    FrameWidthRst  = DimW'(1920);
	localparam logic [DimW-1:0]    FrameHeightRst = DimW'(1080);
	localparam logic [StrideW-1:0] DestStrideRst  = StrideW'(1920);

	typedef enum logic [1:0] {
		RotNone,
		Rot90,
		Rot180,
		Rot270
	} rot_t;

	typedef enum logic [1:0] {
		RegFrameWidth,
		RegFrameHeight,
		RegRotation,
		RegDestStride
	} reg_idx_t;

endpackage

FILE: hdl/yuvrot_ifs.sv
// Valid/ready channel interfaces for pixels in and converted pixels out.
interface yuvrot_in_if import yuvrot_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ChanW-1:0]  luma;
	logic [ChanW-1:0]  chroma_blue;
	logic [ChanW-1:0]  chroma_red;
	logic [CoordW-1:0] column;
	logic [CoordW-1:0] line;

	modport source (output valid, luma, chroma_blue, chroma_red, column, line, input ready);
	modport sink (input valid, luma, chroma_blue, chroma_red, column, line, output ready);
endinterface

interface yuvrot_out_if import yuvrot_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ArgbW-1:0] argb_pixel;
	logic [IdxW-1:0]  dest_index;
	logic [DimW-1:0]  rotated_width;
	logic [DimW-1:0]  rotated_height;

	modport source (output valid, argb_pixel, dest_index, rotated_width, rotated_height,
		input ready);
	modport sink (input valid, argb_pixel, dest_index, rotated_width, rotated_height,
		output ready);
endinterface

FILE: hdl/yuv420_to_argb_rotate_top.sv
// Top level: BT.601 YUV to ARGB conversion with rotated destination index.
//
//   channel   kind        carries
//   pixel     sink        luma, chroma_blue, chroma_red, column, line
//   result    source      argb_pixel, dest_index, rotated_width, rotated_height
//   apb       cfg slave   frame_width, frame_height, rotation, dest_stride
//
// Three register stages: chroma products, channel sums with index multiply,
// then clamp, pack and index add into the output register.
// One pixel per cycle while the result side does not hold the output off.
// Each stage advances when it is empty or the next one advances, so bubbles
// collapse; while a result waits at the output the input stays ready until
// all three stages hold an item.
// Reset clears the valid bits and restores the configuration defaults.
`include "yuv420_to_argb_rotate_top_defines.svh"

module yuv420_to_argb_rotate_top import yuvrot_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	yuvrot_in_if.sink        pixel,
	yuvrot_out_if.source     result
);

	localparam int QW = SumW - FracW;

	// Configuration: raw values for readback plus saturated forms.
	logic [DimW-1:0]    fw_q, fh_q, wsat_q, hsat_q;
	logic [CoordW-1:0]  wm1_q, hm1_q;
	logic [StrideW-1:0] stride_q, ssat_q;
	rot_t               rot_q;
	reg_idx_t           reg_idx;
	logic               wr_en;

	// Pipeline handshake.
	logic v1_s1, v2_s2, v3_s3;
	logic en1, en2, en3;

	// Stage 1.
	logic [ChanW-1:0]        y_s1;
	logic signed [ProdW-1:0] rv_s1, gu_s1, gv_s1, bu_s1;
	logic [CoordW-1:0]       mul_a_s1, add_b_s1;

	// Stage 2.
	logic signed [SumW-1:0] r_s2, g_s2, b_s2;
	logic [IdxW-1:0]        prod_s2;
	logic [CoordW-1:0]      add_b_s2;

	// Stage 3 / output register.
	logic [ArgbW-1:0] argb_s3;
	logic [IdxW-1:0]  idx_s3;

	// Input-side combinational signals.
	logic signed [ChromaW-1:0] u_in, v_in;
	logic [CoordW-1:0]         x_c, y_c, x_i, y_i, mul_a, add_b;
	logic signed [SumW-1:0]    luma_term;
	logic                      swap;

	function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v);
		logic [DimW-1:0] r;
		if (v == '0) r = DimW'(1);
		else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
		else r = v;
		return r;
	endfunction

	function automatic logic [StrideW-1:0] sat_stride(input logic [StrideW-1:0] v);
		logic [StrideW-1:0] r;
		if (v == '0) r = StrideW'(1);
		else if (v > StrideW'(MaxStride)) r = StrideW'(MaxStride);
		else r = v;
		return r;
	endfunction

	// Floor of v / 2^16, clamped to a byte.
	function automatic logic [ChanW-1:0] clamp_chan(input logic signed [SumW-1:0] v);
		logic signed [QW-1:0] q;
		logic [ChanW-1:0]     r;
		q = QW'(v >>> FracW);
		if (q < 0) r = '0;
		else if (q > $signed(QW'(ChanMax))) r = ChanW'(ChanMax);
		else r = q[ChanW-1:0];
		return r;
	endfunction

	// Configuration port.
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = reg_idx_t'(paddr[AddrW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= FrameWidthRst;
			fh_q     <= FrameHeightRst;
			wsat_q   <= FrameWidthRst;
			hsat_q   <= FrameHeightRst;
			wm1_q    <= CoordW'(FrameWidthRst - DimW'(1));
			hm1_q    <= CoordW'(FrameHeightRst - DimW'(1));
			rot_q    <= RotNone;
			stride_q <= DestStrideRst;
			ssat_q   <= DestStrideRst;
		end else if (wr_en) begin
			unique case (reg_idx)
				RegFrameWidth: begin
					fw_q   <= pwdata[DimW-1:0];
					wsat_q <= sat_dim(pwdata[DimW-1:0]);
					wm1_q  <= CoordW'(sat_dim(pwdata[DimW-1:0]) - DimW'(1));
				end
				RegFrameHeight: begin
					fh_q   <= pwdata[DimW-1:0];
					hsat_q <= sat_dim(pwdata[DimW-1:0]);
					hm1_q  <= CoordW'(sat_dim(pwdata[DimW-1:0]) - DimW'(1));
				end
				RegRotation: begin
					rot_q <= rot_t'(pwdata[1:0]);
				end
				RegDestStride: begin
					stride_q <= pwdata[StrideW-1:0];
					ssat_q   <= sat_stride(pwdata[StrideW-1:0]);
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegFrameWidth:  prdata = DataW'(fw_q);
			RegFrameHeight: prdata = DataW'(fh_q);
			RegRotation:    prdata = DataW'(rot_q);
			RegDestStride:  prdata = DataW'(stride_q);
		endcase
	end

	// Stall chain: a stage advances when empty or when the next one advances.
	assign en3         = !v3_s3 || result.ready;
	assign en2         = !v2_s2 || en3;
	assign en1         = !v1_s1 || en2;
	assign pixel.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= pixel.valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
		end
	end

	// Stage 1 inputs: chroma offsets and rotation operands.
	assign u_in = $signed({1'b0, pixel.chroma_blue}) - ChromaW'(ChromaOfs);
	assign v_in = $signed({1'b0, pixel.chroma_red}) - ChromaW'(ChromaOfs);
	assign x_c  = (pixel.column > wm1_q) ? wm1_q : pixel.column;
	assign y_c  = (pixel.line > hm1_q) ? hm1_q : pixel.line;
	assign x_i  = wm1_q - x_c;
	assign y_i  = hm1_q - y_c;

	always_comb begin
		case (rot_q)
			RotNone: begin
				mul_a = y_c;
				add_b = x_c;
			end
			Rot90: begin
				mul_a = x_c;
				add_b = y_i;
			end
			Rot180: begin
				mul_a = y_i;
				add_b = x_i;
			end
			Rot270: begin
				mul_a = x_i;
				add_b = y_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			y_s1     <= pixel.luma;
			rv_s1    <= ProdW'(v_in) * CoefRv;
			gu_s1    <= ProdW'(u_in) * CoefGu;
			gv_s1    <= ProdW'(v_in) * CoefGv;
			bu_s1    <= ProdW'(u_in) * CoefBu;
			mul_a_s1 <= mul_a;
			add_b_s1 <= add_b;
		end
	end

	// Stage 2: channel sums in signed 10.16 and the row multiply.
	assign luma_term = $signed(SumW'({y_s1, {FracW{1'b0}}}));

	always_ff @(posedge clk) begin
		if (en2) begin
			r_s2     <= luma_term + SumW'(rv_s1);
			g_s2     <= luma_term - SumW'(gu_s1) - SumW'(gv_s1);
			b_s2     <= luma_term + SumW'(bu_s1);
			prod_s2  <= IdxW'(mul_a_s1) * IdxW'(ssat_q);
			add_b_s2 <= add_b_s1;
		end
	end

	// Stage 3: clamp, pack and finish the index.
	always_ff @(posedge clk) begin
		if (en3) begin
			argb_s3 <= {AlphaOpaque, clamp_chan(r_s2), clamp_chan(g_s2), clamp_chan(b_s2)};
			idx_s3  <= prod_s2 + IdxW'(add_b_s2);
		end
	end

	// The user must change the frame size only while idle; the block does not enforce it and takes it from the registers.
	assign swap = (rot_q == Rot90) || (rot_q == Rot270);

	assign result.valid          = v3_s3;
	assign result.argb_pixel     = argb_s3;
	assign result.dest_index     = idx_s3;
	assign result.rotated_width  = swap ? hsat_q : wsat_q;
	assign result.rotated_height = swap ? wsat_q : hsat_q;

	`YR_ASSERT(a_ready_when_drained, !result.valid |-> pixel.ready, "input stalled with empty output")
	`YR_ASSERT(a_alpha_opaque, result.valid |-> (result.argb_pixel[31:24] == AlphaOpaque), "alpha not opaque")
	`YR_NEXT(a_stage2_advance, v2_s2 && !result.valid, result.valid, "stage 2 item did not advance")

endmodule

FILE: tb/yuv420_to_argb_rotate_top_tb.sv
// Self-checking testbench for the YUV to ARGB conversion block with rotated destination index.
module yuv420_to_argb_rotate_top_tb;
	import yuvrot_pkg::*;

	localparam int WatchdogLimit = 4000;
	localparam int SettleCycles  = 6;
	localparam int HoldOffCycles = 300;

	localparam longint FixOne = 65536;
	localparam longint KRv    = 91881;
	localparam longint KGu    = 22554;
	localparam longint KGv    = 46802;
	localparam longint KBu    = 116130;

	typedef struct packed {
		logic [ChanW-1:0]  luma;
		logic [ChanW-1:0]  chroma_blue;
		logic [ChanW-1:0]  chroma_red;
		logic [CoordW-1:0] column;
		logic [CoordW-1:0] line;
	} pixel_item_t;

	typedef struct packed {
		logic [ArgbW-1:0] argb_pixel;
		logic [IdxW-1:0]  dest_index;
		logic [DimW-1:0]  rotated_width;
		logic [DimW-1:0]  rotated_height;
	} argb_result_t;

	bit clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic pready;

	yuvrot_in_if  pixel_ch ();
	yuvrot_out_if result_ch ();

	yuv420_to_argb_rotate_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixel   (pixel_ch),
		.result  (result_ch)
	);

	// Shadow of the configuration registers.
	logic [DimW-1:0]    cfg_width  = FrameWidthRst;
	logic [DimW-1:0]    cfg_height = FrameHeightRst;
	rot_t               cfg_rot    = RotNone;
	logic [StrideW-1:0] cfg_stride = DestStrideRst;

	argb_result_t pending_argb_q[$];
	int mismatch_count = 0;
	int stuck_cycles   = 0;
	bit src_gaps_on    = 1'b1;
	bit rx_gaps_on     = 1'b1;
	int rx_wait        = 0;
	int rx_hold_off    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned sat_dim(input longint unsigned v,
		input longint unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Floor shift is done by the caller; clamp the channel to one byte.
	function automatic logic [ChanW-1:0] clamp_chan(input longint v);
		if (v < 0) return '0;
		if (v > ChanMax) return ChanW'(ChanMax);
		return v[ChanW-1:0];
	endfunction

	function automatic argb_result_t convert_pixel(input pixel_item_t pix);
		argb_result_t res;
		longint ys, us, vs;
		longint unsigned w, h, s, x, y, at;
		ys = longint'(pix.luma);
		us = longint'(pix.chroma_blue) - ChromaOfs;
		vs = longint'(pix.chroma_red) - ChromaOfs;
		w = sat_dim(cfg_width, MaxDim);
		h = sat_dim(cfg_height, MaxDim);
		s = sat_dim(cfg_stride, MaxStride);
		x = (pix.column > w - 1) ? w - 1 : pix.column;
		y = (pix.line > h - 1) ? h - 1 : pix.line;
		case (cfg_rot)
			Rot90:   at = x * s + (h - 1 - y);
			Rot180:  at = (h - 1 - y) * s + (w - 1 - x);
			Rot270:  at = (w - 1 - x) * s + y;
			default: at = y * s + x;
		endcase
		res.argb_pixel = {AlphaOpaque,
			clamp_chan((FixOne * ys + KRv * vs) >>> FracW),
			clamp_chan((FixOne * ys - KGu * us - KGv * vs) >>> FracW),
			clamp_chan((FixOne * ys + KBu * us) >>> FracW)};
		res.dest_index = at[IdxW-1:0];
		if (cfg_rot == Rot90 || cfg_rot == Rot270) begin
			res.rotated_width  = DimW'(h);
			res.rotated_height = DimW'(w);
		end else begin
			res.rotated_width  = DimW'(w);
			res.rotated_height = DimW'(h);
		end
		return res;
	endfunction

	function automatic pixel_item_t make_pixel(input int y, input int u, input int v,
		input int col, input int row);
		pixel_item_t pix;
		pix.luma        = ChanW'(y);
		pix.chroma_blue = ChanW'(u);
		pix.chroma_red  = ChanW'(v);
		pix.column      = CoordW'(col);
		pix.line        = CoordW'(row);
		return pix;
	endfunction

	// Mostly positions inside the frame; some anywhere in the coordinate range.
	function automatic pixel_item_t random_pixel();
		longint unsigned w, h;
		int col, row;
		w = sat_dim(cfg_width, MaxDim);
		h = sat_dim(cfg_height, MaxDim);
		if ($urandom_range(0, 4) == 0) begin
			col = $urandom_range(0, MaxDim - 1);
			row = $urandom_range(0, MaxDim - 1);
		end else begin
			col = $urandom_range(0, int'(w - 1));
			row = $urandom_range(0, int'(h - 1));
		end
		return make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), col, row);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_pixel(input pixel_item_t pix);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			pixel_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_ch.valid       = 1'b1;
		pixel_ch.luma        = pix.luma;
		pixel_ch.chroma_blue = pix.chroma_blue;
		pixel_ch.chroma_red  = pix.chroma_red;
		pixel_ch.column      = pix.column;
		pixel_ch.line        = pix.line;
		do @(posedge clk); while (!pixel_ch.ready);
		pending_argb_q.push_back(convert_pixel(pix));
		@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] value);
		logic [DataW-1:0] want;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = AddrW'({idx, 2'b00});
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			RegFrameWidth: begin
				cfg_width = value[DimW-1:0];
				want      = DataW'(cfg_width);
			end
			RegFrameHeight: begin
				cfg_height = value[DimW-1:0];
				want       = DataW'(cfg_height);
			end
			RegRotation: begin
				cfg_rot = rot_t'(value[1:0]);
				want    = DataW'(cfg_rot);
			end
			RegDestStride: begin
				cfg_stride = value[StrideW-1:0];
				want       = DataW'(cfg_stride);
			end
		endcase
		@(negedge clk);
		// Read the register back.
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$display("%0t: readback expected 0x%0h, got 0x%0h", $time, want, prdata);
			mismatch_count++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic wait_drain();
		while (pending_argb_q.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic set_frame(input int w, input int h, input rot_t rot, input int stride);
		pixel_ch.valid = 1'b0;
		wait_drain();
		write_reg(RegFrameWidth, DataW'(w));
		write_reg(RegFrameHeight, DataW'(h));
		write_reg(RegRotation, DataW'(rot));
		write_reg(RegDestStride, DataW'(stride));
	endtask

	// Reset configuration: gray, saturated colors and chroma extremes.
	task automatic test_color_extremes();
		send_pixel(make_pixel(0, 128, 128, 0, 0));
		send_pixel(make_pixel(255, 128, 128, 1919, 1079));
		send_pixel(make_pixel(0, 0, 0, 4095, 4095));
		send_pixel(make_pixel(255, 255, 255, 1, 0));
		send_pixel(make_pixel(255, 0, 255, 0, 1));
		send_pixel(make_pixel(0, 255, 0, 2048, 1080));
		send_pixel(make_pixel(128, 0, 0, 1920, 7));
		send_pixel(make_pixel(128, 255, 255, 2730, 1365));
		send_pixel(make_pixel(1, 1, 254, 1365, 2730));
	endtask

	task automatic test_rotations();
		rot_t rot;
		for (int r = 0; r < 4; r++) begin
			rot = rot_t'(r);
			set_frame(7, 5, rot, 11);
			send_pixel(make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), 0, 0));
			send_pixel(make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), 6, 4));
		end
	endtask

	// Zero and oversized frame sizes and strides saturate.
	task automatic test_size_saturation();
		set_frame(0, 0, Rot90, 0);
		send_pixel(make_pixel(77, 200, 30, 0, 0));
		send_pixel(make_pixel(180, 40, 220, 4095, 4095));
		set_frame(8191, 8191, Rot180, 16383);
		send_pixel(make_pixel(16, 128, 128, 0, 0));
		send_pixel(make_pixel(235, 240, 16, 4095, 4095));
		set_frame(MaxDim, MaxDim, Rot270, MaxStride);
		send_pixel(make_pixel(100, 90, 240, 0, 4095));
	endtask

	task automatic test_random_frames();
		int kind;
		rot_t rot;
		for (int phase = 0; phase < 10; phase++) begin
			kind = $urandom_range(0, 9);
			rot  = rot_t'($urandom_range(0, 3));
			if (kind == 0)
				set_frame($urandom_range(0, 8191), $urandom_range(0, 8191), rot,
					$urandom_range(0, 16383));
			else
				set_frame($urandom_range(1, 48), $urandom_range(1, 48), rot,
					$urandom_range(1, 100));
			src_gaps_on = ($urandom_range(0, 3) != 0);
			rx_gaps_on  = ($urandom_range(0, 3) != 0);
			repeat (70) send_pixel(random_pixel());
		end
		src_gaps_on = 1'b1;
		rx_gaps_on  = 1'b1;
	endtask

	// Hold the output off long enough for the pipeline to fill and stall the input.
	task automatic test_output_backpressure();
		set_frame(64, 32, Rot90, 40);
		src_gaps_on = 1'b0;
		rx_gaps_on  = 1'b0;
		@(posedge clk);
		rx_hold_off = HoldOffCycles;
		@(negedge clk);
		repeat (40) send_pixel(random_pixel());
		src_gaps_on = 1'b1;
		rx_gaps_on  = 1'b1;
	endtask

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(negedge clk) begin
		if (rx_hold_off > 0) begin
			result_ch.ready = 1'b0;
			rx_hold_off--;
		end else if (rx_wait > 0) begin
			result_ch.ready = 1'b0;
			rx_wait--;
		end else begin
			result_ch.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		argb_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			rx_wait = rx_gaps_on ? $urandom_range(0, 19) : 0;
			if (pending_argb_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got argb 0x%0h index 0x%0h",
					$time, result_ch.argb_pixel, result_ch.dest_index);
				mismatch_count++;
			end else begin
				want = pending_argb_q.pop_front();
				check_field("argb_pixel", want.argb_pixel, result_ch.argb_pixel);
				check_field("dest_index", want.dest_index, result_ch.dest_index);
				check_field("rotated_width", want.rotated_width, result_ch.rotated_width);
				check_field("rotated_height", want.rotated_height, result_ch.rotated_height);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= WatchdogLimit) begin
				$display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		pixel_ch.valid       = 1'b0;
		pixel_ch.luma        = '0;
		pixel_ch.chroma_blue = '0;
		pixel_ch.chroma_red  = '0;
		pixel_ch.column      = '0;
		pixel_ch.line        = '0;
		result_ch.ready      = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_color_extremes();
		test_rotations();
		test_size_saturation();
		test_random_frames();
		test_output_backpressure();
		pixel_ch.valid = 1'b0;
		wait_drain();
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
